@@ sv/pget_pkg.sv @@
// Shared types and constants for the priority gated entry table.
package pget_pkg;
    localparam logic [1:0] FUNC_GATE  = 2'd0;
    localparam logic [1:0] FUNC_FOCUS = 2'd1;
    localparam logic [1:0] FUNC_SET   = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic [2:0] REG_THRESH  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_SLOTS   = 3'd2;
    localparam logic [2:0] REG_FLOOR   = 3'd3;
    localparam logic [2:0] REG_CEIL    = 3'd4;

    localparam logic [15:0] BOOST_Q15 = 16'd39322;
    localparam logic [4:0]  DEFAULT_SLOTS = 5'd7;

    // Datapath commands.
    typedef struct packed {
        logic load;      // capture input item and search
        logic step1;     // gate/set write, or decay of old focus
        logic step2;     // boost of new focus (search repeated)
        logic finish;    // register result
    } t_cmd;

    typedef struct packed {
        logic is_focus;
    } t_status;

    function automatic logic [15:0] clamp_prio(input logic [16:0] v,
                                               input logic [15:0] lo,
                                               input logic [15:0] hi);
        if (v < {1'b0, lo}) return lo;
        if (v > {1'b0, hi}) return hi;
        return v[15:0];
    endfunction
endpackage

@@ sv/priority_gated_entry_table_top.sv @@
// Steps: load and search, step1 (gate/set write or old focus decay), step2 (focus shift only,
// new focus boost), finish; a single search and write sequencer takes no input until finish.
// The next input is taken while a result waits in the output register; its own result
// waits in the sequencer until that register is free.
// Reset: synchronous active low, clears all entries and loads register defaults.
module priority_gated_entry_table_top import pget_pkg::*; #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_WIDTH  = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // target_id, previous_id, level
    input  logic [1:0]   s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,  // was_present, slot_index, did_evict, evicted_id,
                                        // target_priority, entry_count
    output logic [1:0]   m_axis_tuser,  // status
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    t_cmd    cmd;
    t_status stat;
    logic    busy, r_ov;
    logic [1:0] st; logic pr, ev; logic [3:0] sl; logic [63:0] eid;
    logic [15:0] pp; logic [4:0] cn;

    assign s_axis_tready = !busy;

    pget_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_free(!r_ov), .i_stat(stat), .o_cmd(cmd), .o_busy(busy)
    );

    pget_dp #(.MAX_SLOTS(MAX_SLOTS), .ID_WIDTH(ID_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_func(s_axis_tuser), .i_tid(s_axis_tdata[63:0]),
        .i_pid(s_axis_tdata[127:64]), .i_level(s_axis_tdata[143:128]),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_status(st), .o_present(pr), .o_slot(sl), .o_evict(ev),
        .o_evid(eid), .o_prio(pp), .o_count(cn)
    );

    logic [90:0] r_dat;
    logic [1:0]  r_usr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (cmd.finish) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_dat <= {cn, pp, eid, ev, sl, pr};
            r_usr <= st;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'b00000, r_dat};
    assign m_axis_tuser  = r_usr;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready) else $error("accept while busy");
    a_finish_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> !r_ov) else $error("result overwritten");
    a_evict_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tuser == ST_DONE)
        else $error("evict with bad status");
`endif
endmodule

@@ sv/pget_ctrl.sv @@
// Sequencer for one operation of the entry table.
module pget_ctrl import pget_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_fire,
    input  logic    i_out_free,
    input  t_status i_stat,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ONE  = 4'b0010,
        S_TWO  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_ONE;
                end
            end
            S_ONE: begin
                o_cmd.step1 = 1'b1;
                n_state = i_stat.is_focus ? S_TWO : S_FIN;
            end
            S_TWO: begin
                o_cmd.step2 = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ sv/pget_dp.sv @@
// Entry table storage, search and priority arithmetic.
module pget_dp import pget_pkg::*; #(
    parameter int MAX_SLOTS = 16,
    parameter int ID_WIDTH  = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_stat,
    input  logic [1:0]          i_func,
    input  logic [63:0]         i_tid,
    input  logic [63:0]         i_pid,
    input  logic [15:0]         i_level,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic [1:0]          o_status,
    output logic                o_present,
    output logic [3:0]          o_slot,
    output logic                o_evict,
    output logic [63:0]         o_evid,
    output logic [15:0]         o_prio,
    output logic [4:0]          o_count
);
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    logic [ID_WIDTH-1:0] r_ids [MAX_SLOTS];
    logic [15:0]         r_pri [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_val;
    logic [CW-1:0]       r_cnt;

    logic [15:0] r_thresh, r_decay, r_floor, r_ceil;
    logic [4:0]  r_slots;

    logic [1:0]          r_func;
    logic [ID_WIDTH-1:0] r_tid, r_pid;
    logic [15:0]         r_level;
    logic                r_hit_t, r_hit_p, r_free_ok;
    logic [SW-1:0]       r_idx_t, r_idx_p, r_idx_f;

    logic [1:0]  r_status;
    logic        r_present, r_evict;
    logic [SW-1:0] r_slot;
    logic [ID_WIDTH-1:0] r_evid;
    logic [15:0] r_prio;

    logic [CW-1:0] cap;
    always_comb begin
        if (r_slots == 5'd0) begin
            cap = (DEFAULT_SLOTS < CW'(MAX_SLOTS)) ? CW'(DEFAULT_SLOTS) : CW'(MAX_SLOTS);
        end else if ({27'd0, r_slots} > MAX_SLOTS) begin
            cap = CW'(MAX_SLOTS);
        end else begin
            cap = CW'(r_slots);
        end
    end

    // Parallel match, first free and lowest-priority search.
    logic [ID_WIDTH-1:0] ld_tid, ld_pid, s_tid;
    logic          f_hit_t, f_hit_p, f_free;
    logic [SW-1:0] f_idx_t, f_idx_p, f_idx_f, f_idx_l;
    logic [15:0]   f_min;
    logic          f_any;
    assign ld_tid = i_tid[ID_WIDTH-1:0];
    assign ld_pid = i_pid[ID_WIDTH-1:0];
    assign s_tid  = i_cmd.load ? ld_tid : r_tid;

    always_comb begin
        f_hit_t = 1'b0; f_hit_p = 1'b0; f_free = 1'b0; f_any = 1'b0;
        f_idx_t = '0; f_idx_p = '0; f_idx_f = '0; f_idx_l = '0; f_min = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (CW'(i) < cap) begin
                if (r_val[i] && r_ids[i] == s_tid) begin
                    f_hit_t = 1'b1; f_idx_t = SW'(i);
                end
                if (r_val[i] && r_ids[i] == ld_pid) begin
                    f_hit_p = 1'b1; f_idx_p = SW'(i);
                end
                if (!r_val[i]) begin
                    f_free = 1'b1; f_idx_f = SW'(i);
                end
            end
        end
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (CW'(i) < cap && r_val[i] && (!f_any || r_pri[i] < f_min)) begin
                f_any = 1'b1; f_idx_l = SW'(i); f_min = r_pri[i];
            end
        end
    end

    logic [15:0] lvl_c;
    assign lvl_c = clamp_prio({1'b0, r_level}, r_floor, r_ceil);

    // Decay and boost, each with its own multiplier.
    logic [16:0] dec_f;
    logic [32:0] dec_p;
    logic [31:0] bst_p;
    logic [15:0] p_old, p_new;
    assign dec_f = 17'h10000 - {1'b0, r_decay};
    assign p_old = r_pri[r_idx_p];
    assign dec_p = {17'd0, p_old} * {16'd0, dec_f};
    assign p_new = r_pri[f_idx_t];
    assign bst_p = {16'd0, p_new} * {16'd0, BOOST_Q15};
    logic [15:0] boosted;
    assign boosted = clamp_prio(bst_p[31:15], r_floor, r_ceil);

    assign o_stat.is_focus = (r_func == FUNC_FOCUS);

    // Result and table write of the first step.
    logic [1:0]          n_status;
    logic                n_present, n_evict;
    logic [SW-1:0]       n_slot;
    logic [ID_WIDTH-1:0] n_evid;
    logic [15:0]         n_prio;
    logic                n_wr, n_ins;
    logic [SW-1:0]       n_wr_idx;
    logic [15:0]         n_wr_pri;

    always_comb begin
        n_status = ST_DONE; n_present = 1'b0; n_slot = '0; n_evict = 1'b0;
        n_evid = '0; n_prio = '0;
        n_wr = 1'b0; n_ins = 1'b0; n_wr_idx = '0; n_wr_pri = '0;
        case (r_func)
            FUNC_GATE: begin
                if (r_level < r_thresh) begin
                    n_status = ST_REJECT;
                end else if (r_hit_t) begin
                    n_present = 1'b1; n_slot = r_idx_t; n_prio = lvl_c;
                    n_wr = 1'b1; n_wr_idx = r_idx_t; n_wr_pri = lvl_c;
                end else if (r_free_ok) begin
                    n_slot = r_idx_f; n_prio = lvl_c;
                    n_wr = 1'b1; n_wr_idx = r_idx_f; n_wr_pri = lvl_c;
                    n_ins = 1'b1; n_evict = r_evict;
                    if (r_evict) n_evid = r_ids[r_idx_f];
                end
            end
            FUNC_FOCUS: begin
                if (r_hit_p) begin
                    n_wr = 1'b1; n_wr_idx = r_idx_p;
                    n_wr_pri = clamp_prio(dec_p[32:16], r_floor, r_ceil);
                end
            end
            FUNC_SET: begin
                if (r_hit_t) begin
                    n_present = 1'b1; n_slot = r_idx_t; n_prio = lvl_c;
                    n_wr = 1'b1; n_wr_idx = r_idx_t; n_wr_pri = lvl_c;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: ;
        endcase
    end

    logic wr_clear;
    assign wr_clear = i_cfg_we && i_cfg_idx == REG_SLOTS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0; r_cnt <= '0;
            r_thresh <= 16'd9830; r_decay <= 16'd6554; r_slots <= DEFAULT_SLOTS;
            r_floor <= 16'd0; r_ceil <= 16'd32768;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESH: r_thresh <= i_cfg_data;
                    REG_DECAY:  r_decay  <= i_cfg_data;
                    REG_SLOTS:  r_slots  <= i_cfg_data[4:0];
                    REG_FLOOR:  r_floor  <= i_cfg_data;
                    REG_CEIL:   r_ceil   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (wr_clear) begin
                r_val <= '0; r_cnt <= '0;
            end else if (i_cmd.step1 && n_ins) begin
                r_val[r_idx_f] <= 1'b1;
                if (!n_evict) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func; r_tid <= ld_tid; r_pid <= ld_pid; r_level <= i_level;
            r_hit_t <= f_hit_t; r_hit_p <= f_hit_p && (ld_pid != '0);
            r_idx_t <= f_idx_t; r_idx_p <= f_idx_p;
            r_free_ok <= f_free || f_any;
            r_idx_f <= f_free ? f_idx_f : f_idx_l;
            r_evict <= !f_free && f_any;
        end
        if (i_cmd.step1) begin
            r_status <= n_status; r_present <= n_present; r_slot <= n_slot;
            r_evict <= n_evict; r_evid <= n_evid; r_prio <= n_prio;
            if (n_wr) r_pri[n_wr_idx] <= n_wr_pri;
            if (n_ins) r_ids[r_idx_f] <= r_tid;
        end
        if (i_cmd.step2 && f_hit_t) begin
            r_pri[f_idx_t] <= boosted;
            r_present <= 1'b1; r_slot <= f_idx_t; r_prio <= boosted;
        end
    end

    assign o_status  = r_status;
    assign o_present = r_present;
    assign o_slot    = 4'(r_slot);
    assign o_evict   = r_evict;
    assign o_evid    = 64'(r_evid);
    assign o_prio    = r_prio;
    assign o_count   = 5'(r_cnt);
endmodule
